### sv/sch_pkg.sv
// ----------------------------------------------------------------------------
// sch_pkg
// Shared constants, register codes and the sine table for the stereo chorus.
// ----------------------------------------------------------------------------
package sch_pkg;

    localparam int LINE_DEPTH   = 1024;
    localparam int SINE_ENTRIES = 1024;

    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int SINE_AW = $clog2(SINE_ENTRIES + 1);

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_MIX   = 3'd0,
        REG_DEPTH = 3'd1,
        REG_RATE  = 3'd2,
        REG_SPMS  = 3'd3,
        REG_RAMP  = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] MIX_RESET   = 16'd32768;
    localparam logic [15:0] DEPTH_RESET = 16'd13107;
    localparam logic [22:0] RATE_RESET  = 23'd17895;
    localparam logic [15:0] SPMS_RESET  = 16'd12288;
    localparam logic [13:0] RAMP_RESET  = 14'd2400;

    typedef logic signed [24:0] sine_rom_t [SINE_ENTRIES + 1];

    // polynomial sine over one quarter turn, Q1.23
    function automatic logic signed [24:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        x  = (longint'(k) * TWO_PI_Q30) / SINE_ENTRIES;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return 25'((((x * t) >> 30) + 64) >> 7);
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        int unsigned q;
        q = SINE_ENTRIES / 4;
        for (int unsigned i = 0; i <= SINE_ENTRIES; i++)
        begin
            if (i <= q)
                rom[i] = quarter_sine(i);
            else if (i <= 2 * q)
                rom[i] = quarter_sine(2 * q - i);
            else if (i <= 3 * q)
                rom[i] = -quarter_sine(i - 2 * q);
            else
                rom[i] = -quarter_sine(SINE_ENTRIES - i);
        end
        return rom;
    endfunction

endpackage

### sv/stereo_chorus.sv
// ----------------------------------------------------------------------------
// stereo_chorus
// LFO-swept delay chorus: each channel goes through its own delay line, read
// back at a swept fractional delay with linear interpolation and mixed with
// the dry sample. Mix, depth and LFO rate glide to new values after the first item, if the ramp is nonzero.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   left_in, right_in
//  out      out_valid / out_ready left_out, right_out
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  each item passes through the sequencer states S_SIN0 to S_MIX2, which share
//  the sine rom port and the single read port of each delay memory;
//  the next item is taken only once the sequencer is back in S_IDLE.
//  after reset a clearing pass zeroes every entry of the delay memories;
//  no item is taken meanwhile, configuration writes are.
//  a glide write after the first item runs a bit-serial divider; cfg_ready and
//  in_ready stay low while it runs. in_ready is also low while cfg_valid is
//  high. a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module stereo_chorus
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] left_in,
    input  logic signed [23:0] right_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] left_out,
    output logic signed [23:0] right_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int LAW = sch_pkg::LINE_AW;
    localparam int SAW = sch_pkg::SINE_AW;
    localparam int PW  = 32 + SAW;
    localparam logic [36:0] DLY_MAX = 37'(sch_pkg::LINE_DEPTH - 2) << 16;
    localparam sch_pkg::sine_rom_t SINE_ROM = sch_pkg::build_sine();

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SIN0, S_SIN1, S_SIN2, S_MS0, S_MS1, S_DLY,
        S_RD0, S_RD1, S_WET0, S_WET1, S_MIX0, S_MIX1, S_MIX2
    } state_t;

    state_t state_reg;
    logic [LAW-1:0] clear_cnt_reg;
    logic [LAW-1:0] wp_reg;
    logic [31:0]    phase_reg;
    logic           started_reg;
    logic           out_valid_reg;

    logic [15:0] mix_reg, depth_reg, spms_reg;
    logic [22:0] rate_reg;
    logic [13:0] ramp_reg;

    logic signed [39:0] rv_reg  [3];
    logic signed [39:0] inc_reg [3];
    logic [13:0]        cnt_reg [3];

    // glide divider
    logic        div_busy_reg;
    logic [5:0]  div_cnt_reg;
    logic [1:0]  div_which_reg;
    logic        div_neg_reg;
    logic [39:0] div_num_reg;
    logic [14:0] div_rem_reg;
    logic [13:0] div_len_reg;

    // datapath registers
    logic signed [23:0] xl_reg, xr_reg;
    logic [16:0]        wmix_reg;
    logic [15:0]        dep_reg;
    logic [22:0]        grate_reg;
    logic [SAW-1:0]     idx_reg;
    logic [15:0]        pf_reg;
    logic signed [24:0] rom_q_reg;
    logic signed [24:0] t0_reg;
    logic signed [42:0] sprod_reg;
    logic signed [25:0] s_reg;
    logic signed [43:0] mprod_reg;
    logic [20:0]        ms_reg;
    logic [LAW-1:0]     at_reg;
    logic [15:0]        frac_reg;
    logic signed [23:0] nl_reg, nr_reg, ol_reg, or_reg;
    logic signed [41:0] wpl_reg, wpr_reg;
    logic signed [25:0] wetl_reg, wetr_reg;
    logic signed [44:0] dryl_reg, dryr_reg;
    logic signed [43:0] wetpl_reg, wetpr_reg;
    logic signed [23:0] left_out_reg, right_out_reg;

    // delay memories
    logic signed [23:0] mem_l [sch_pkg::LINE_DEPTH];
    logic signed [23:0] mem_r [sch_pkg::LINE_DEPTH];
    logic signed [23:0] ql_reg, qr_reg;
    logic               mem_we;
    logic [LAW-1:0]     mem_waddr, mem_raddr;
    logic signed [23:0] mem_wl, mem_wr;
    logic [SAW-1:0]     rom_addr;

    logic in_acc, cfg_acc, out_free;
    logic [PW-1:0] p_full;

    logic [22:0]        tgt   [3];
    logic signed [39:0] rv_n  [3];
    logic [13:0]        cnt_n [3];

    logic [36:0]        dprod;
    logic [36:0]        dly;
    logic [LAW-1:0]     whole;
    logic signed [47:0] ms_ten;
    logic signed [47:0] ms_s;
    logic signed [44:0] ysum_l, ysum_r;
    logic [15:0]        cfg_v16;
    logic [22:0]        cfg_v23;
    logic [1:0]         cfg_which;
    logic               cfg_glide;
    logic signed [40:0] cfg_diff;
    logic [15:0]        div_r;
    logic               div_bit;

    // a pending register write goes first
    assign in_ready  = (state_reg == S_IDLE) && !div_busy_reg && !cfg_valid;
    assign cfg_ready = ((state_reg == S_IDLE) || (state_reg == S_CLEAR)) && !div_busy_reg;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    assign p_full = PW'(phase_reg) * PW'(sch_pkg::SINE_ENTRIES);

    function automatic logic signed [23:0] sat24(input logic signed [44:0] v);
        logic signed [28:0] y;
        y = 29'(v >>> 16);
        if (y > 29'sd8388607)
            return 24'sh7FFFFF;
        else if (y < -29'sd8388608)
            return 24'sh800000;
        else
            return 24'(y);
    endfunction

    // glide one frame forward
    always_comb
    begin
        tgt[0] = 23'(mix_reg);
        tgt[1] = 23'(depth_reg);
        tgt[2] = rate_reg;
        for (int k = 0; k < 3; k++)
        begin
            rv_n[k]  = rv_reg[k];
            cnt_n[k] = cnt_reg[k];
            if (cnt_reg[k] != 14'd0)
            begin
                cnt_n[k] = cnt_reg[k] - 14'd1;
                if (cnt_reg[k] == 14'd1)
                    rv_n[k] = 40'(tgt[k]) <<< 16;
                else
                    rv_n[k] = rv_reg[k] + inc_reg[k];
            end
        end
    end

    always_comb
    begin
        dprod = 37'(ms_reg) * 37'(spms_reg);
        dly   = ((dprod >> 8) > DLY_MAX) ? DLY_MAX : (dprod >> 8);
        whole = dly[LAW+15:16];
        ms_ten = (48'(mprod_reg) <<< 3) + (48'(mprod_reg) <<< 1);
        ms_s   = 48'sd458752 + (ms_ten >>> 23);
        ysum_l = dryl_reg + 45'(wetpl_reg);
        ysum_r = dryr_reg + 45'(wetpr_reg);
    end

    always_comb
    begin
        cfg_v16   = cfg_data[15:0];
        cfg_v23   = cfg_data[22:0];
        cfg_which = cfg_index[1:0];
        cfg_glide = started_reg && (ramp_reg != 14'd0);
        cfg_diff  = 41'sd0;
        unique case (cfg_index)
            sch_pkg::REG_MIX:   cfg_diff = (41'(cfg_v16) <<< 16) - 41'(rv_reg[0]);
            sch_pkg::REG_DEPTH: cfg_diff = (41'(cfg_v16) <<< 16) - 41'(rv_reg[1]);
            sch_pkg::REG_RATE:  cfg_diff = (41'(cfg_v23) <<< 16) - 41'(rv_reg[2]);
            default:            cfg_diff = 41'sd0;
        endcase
        div_r   = {div_rem_reg, div_num_reg[39]};
        div_bit = (div_r >= 16'(div_len_reg));
    end

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg;
        mem_wl    = left_in;
        mem_wr    = right_in;
        mem_raddr = at_reg;
        rom_addr  = p_full[PW-1:32];
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
            mem_wl    = 24'sd0;
            mem_wr    = 24'sd0;
        end
        else if (in_acc)
            mem_we = 1'b1;
        if (state_reg == S_SIN0)
            rom_addr = idx_reg + SAW'(1);
        if (state_reg == S_DLY)
            mem_raddr = wp_reg - whole;
        else if (state_reg == S_RD0)
            mem_raddr = at_reg - LAW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_l[mem_waddr] <= mem_wl;
            mem_r[mem_waddr] <= mem_wr;
        end
        ql_reg    <= mem_l[mem_raddr];
        qr_reg    <= mem_r[mem_raddr];
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    // control, configuration and glide state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            wp_reg        <= '0;
            phase_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mix_reg       <= sch_pkg::MIX_RESET;
            depth_reg     <= sch_pkg::DEPTH_RESET;
            rate_reg      <= sch_pkg::RATE_RESET;
            spms_reg      <= sch_pkg::SPMS_RESET;
            ramp_reg      <= sch_pkg::RAMP_RESET;
            rv_reg[0]     <= 40'(sch_pkg::MIX_RESET) <<< 16;
            rv_reg[1]     <= 40'(sch_pkg::DEPTH_RESET) <<< 16;
            rv_reg[2]     <= 40'(sch_pkg::RATE_RESET) <<< 16;
            for (int k = 0; k < 3; k++)
            begin
                inc_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            div_which_reg <= '0;
            div_neg_reg   <= 1'b0;
            div_num_reg   <= '0;
            div_rem_reg   <= '0;
            div_len_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_MIX2))
                out_valid_reg <= 1'b0;

            if (cfg_acc)
            begin
                unique case (cfg_index)
                    sch_pkg::REG_MIX:   mix_reg   <= cfg_v16;
                    sch_pkg::REG_DEPTH: depth_reg <= cfg_v16;
                    sch_pkg::REG_RATE:  rate_reg  <= cfg_v23;
                    sch_pkg::REG_SPMS:  spms_reg  <= cfg_v16;
                    sch_pkg::REG_RAMP:  ramp_reg  <= cfg_data[13:0];
                    default:            ;
                endcase
                if ((cfg_index == sch_pkg::REG_MIX) || (cfg_index == sch_pkg::REG_DEPTH)
                    || (cfg_index == sch_pkg::REG_RATE))
                begin
                    if (!cfg_glide)
                    begin
                        rv_reg[cfg_which]  <= 40'(cfg_diff) + rv_reg[cfg_which];
                        inc_reg[cfg_which] <= '0;
                        cnt_reg[cfg_which] <= '0;
                    end
                    else
                    begin
                        div_busy_reg  <= 1'b1;
                        div_cnt_reg   <= '0;
                        div_which_reg <= cfg_which;
                        div_neg_reg   <= cfg_diff[40];
                        div_num_reg   <= cfg_diff[40] ? 40'(-cfg_diff) : 40'(cfg_diff);
                        div_rem_reg   <= '0;
                        div_len_reg   <= ramp_reg;
                    end
                end
            end

            // restoring divide, one quotient bit a cycle
            if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd40)
                begin
                    div_busy_reg <= 1'b0;
                    inc_reg[div_which_reg] <= div_neg_reg ? -$signed(div_num_reg)
                                                          : $signed(div_num_reg);
                    cnt_reg[div_which_reg] <= div_len_reg;
                end
                else
                begin
                    div_rem_reg <= div_bit ? 15'(div_r - 16'(div_len_reg)) : div_r[14:0];
                    div_num_reg <= {div_num_reg[38:0], div_bit};
                end
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + LAW'(1);
                    if (clear_cnt_reg == LAW'(sch_pkg::LINE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        started_reg <= 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            rv_reg[k]  <= rv_n[k];
                            cnt_reg[k] <= cnt_n[k];
                        end
                        state_reg <= S_SIN0;
                    end
                end
                S_SIN0:  state_reg <= S_SIN1;
                S_SIN1:  state_reg <= S_SIN2;
                S_SIN2:  state_reg <= S_MS0;
                S_MS0:   state_reg <= S_MS1;
                S_MS1:   state_reg <= S_DLY;
                S_DLY:   state_reg <= S_RD0;
                S_RD0:   state_reg <= S_RD1;
                S_RD1:   state_reg <= S_WET0;
                S_WET0:  state_reg <= S_WET1;
                S_WET1:  state_reg <= S_MIX0;
                S_MIX0:  state_reg <= S_MIX1;
                S_MIX1:  state_reg <= S_MIX2;
                S_MIX2:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        wp_reg        <= wp_reg + LAW'(1);
                        phase_reg     <= phase_reg + 32'(grate_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                xl_reg    <= left_in;
                xr_reg    <= right_in;
                wmix_reg  <= (rv_n[0][31:16] == 16'hFFFF) ? 17'd65536 : 17'(rv_n[0][31:16]);
                dep_reg   <= rv_n[1][31:16];
                grate_reg <= rv_n[2][38:16];
                idx_reg   <= p_full[PW-1:32];
                pf_reg    <= p_full[31:16];
            end
            S_SIN0:
                t0_reg <= rom_q_reg;
            S_SIN1:
                sprod_reg <= (26'(rom_q_reg) - 26'(t0_reg)) * $signed({1'b0, pf_reg});
            S_SIN2:
                s_reg <= 26'(t0_reg) + 26'(sprod_reg >>> 16);
            S_MS0:
                mprod_reg <= $signed({1'b0, dep_reg}) * (-27'(s_reg));
            S_MS1:
                ms_reg <= (ms_s < 48'sd65536) ? 21'd65536 : 21'(ms_s);
            S_DLY:
            begin
                at_reg   <= wp_reg - whole;
                frac_reg <= dly[15:0];
            end
            S_RD0:
            begin
                nl_reg <= ql_reg;
                nr_reg <= qr_reg;
            end
            S_RD1:
            begin
                ol_reg <= ql_reg;
                or_reg <= qr_reg;
            end
            S_WET0:
            begin
                wpl_reg <= $signed({1'b0, frac_reg}) * (25'(ol_reg) - 25'(nl_reg));
                wpr_reg <= $signed({1'b0, frac_reg}) * (25'(or_reg) - 25'(nr_reg));
            end
            S_WET1:
            begin
                wetl_reg <= 26'(nl_reg) + 26'(wpl_reg >>> 16);
                wetr_reg <= 26'(nr_reg) + 26'(wpr_reg >>> 16);
            end
            S_MIX0:
            begin
                dryl_reg <= 45'(xl_reg * $signed({1'b0, 17'(17'd65536 - wmix_reg)}));
                dryr_reg <= 45'(xr_reg * $signed({1'b0, 17'(17'd65536 - wmix_reg)}));
            end
            S_MIX1:
            begin
                wetpl_reg <= 44'(wetl_reg * $signed({1'b0, wmix_reg}));
                wetpr_reg <= 44'(wetr_reg * $signed({1'b0, wmix_reg}));
            end
            S_MIX2:
            begin
                if (out_free)
                begin
                    left_out_reg  <= sat24(ysum_l);
                    right_out_reg <= sat24(ysum_r);
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // divider only runs between items
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (state_reg == S_IDLE))
        else $error("glide divider busy during an item");

    // read-back point keeps the older sample inside the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD0) |-> (wp_reg - at_reg <= LAW'(sch_pkg::LINE_DEPTH - 2)))
        else $error("delay beyond line length");

    // delay floor of one millisecond
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DLY) |-> (ms_reg >= 21'd65536))
        else $error("delay below floor");

    // a result only ever follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> started_reg)
        else $error("result without an item");
`endif

endmodule

### test/stereo_chorus_tb.sv
// ----------------------------------------------------------------------------
// stereo_chorus_tb
// Self-checking bench for the stereo chorus: a queue-fed driver offers stereo
// frames with random gaps, a predictor follows every accepted frame and
// register write, and a monitor compares each output frame with the oldest
// predicted one while the output side stalls at random.
// ----------------------------------------------------------------------------
module stereo_chorus_tb;

    typedef struct packed
    {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } frame_t;

    localparam int WATCHDOG_LIMIT = 6000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    frame_t pending_frames[$];
    frame_t expected_frames[$];
    int     error_count = 0;
    bit     steady_feed;

    // predictor state
    longint      sine_q23 [sch_pkg::SINE_ENTRIES + 1];
    int          line_mem [2][sch_pkg::LINE_DEPTH];
    logic [9:0]  wr_ptr;
    logic [31:0] phase_acc;
    longint      glide_val [3];
    longint      glide_inc [3];
    int          glide_cnt [3];
    bit          running;
    longint      reg_mix, reg_depth, reg_rate, reg_spms, reg_ramp;

    stereo_chorus i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = ~clk;
    end

    // polynomial quarter-turn sine, Q1.23, rounded from Q30
    function automatic longint quarter_wave(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned divs [5];
        divs = '{110, 72, 42, 20, 6};
        x  = k * 64'd6746518852 / sch_pkg::SINE_ENTRIES;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int i = 0; i < 5; i++)
            t = 64'd1073741824 - ((x2 * t) >> 30) / divs[i];
        return longint'((((x * t) >> 30) + 64) >> 7);
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [23:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 24'sh7FFFFF;
        else if (r == 1)
            return -24'sh800000;
        else
            return 24'($urandom);
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic set_glide_target(input int k, input longint target);
        longint goal;
        goal = target << 16;
        if (!running || reg_ramp == 0)
        begin
            glide_val[k] = goal;
            glide_inc[k] = 0;
            glide_cnt[k] = 0;
        end
        else
        begin
            glide_inc[k] = (goal - glide_val[k]) / reg_ramp;
            glide_cnt[k] = int'(reg_ramp);
        end
    endtask

    task automatic step_glide(input int k, input longint target, output longint now_val);
        if (glide_cnt[k] != 0)
        begin
            glide_val[k] += glide_inc[k];
            glide_cnt[k]--;
            if (glide_cnt[k] == 0)
                glide_val[k] = target << 16;
        end
        now_val = glide_val[k] >>> 16;
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [31:0] data);
        case (sch_pkg::cfg_reg_t'(idx))
            sch_pkg::REG_MIX:
            begin
                reg_mix = data[15:0];
                set_glide_target(int'(sch_pkg::REG_MIX), reg_mix);
            end
            sch_pkg::REG_DEPTH:
            begin
                reg_depth = data[15:0];
                set_glide_target(int'(sch_pkg::REG_DEPTH), reg_depth);
            end
            sch_pkg::REG_RATE:
            begin
                reg_rate = data[22:0];
                set_glide_target(int'(sch_pkg::REG_RATE), reg_rate);
            end
            sch_pkg::REG_SPMS: reg_spms = data[15:0];
            sch_pkg::REG_RAMP: reg_ramp = data[13:0];
            default: ;
        endcase
    endtask

    task automatic chorus_frame(input frame_t dry);
        longint mix, depth, rate, wmix, s, ms, dly, frac, newer, older, wet, y, x;
        int idx;
        longint pf;
        logic [9:0] whole, at;
        frame_t res;
        step_glide(int'(sch_pkg::REG_MIX), reg_mix, mix);
        step_glide(int'(sch_pkg::REG_DEPTH), reg_depth, depth);
        step_glide(int'(sch_pkg::REG_RATE), reg_rate, rate);
        running = 1'b1;
        wmix = (mix == 65535) ? 65536 : mix;
        idx = int'(phase_acc >> 22);
        pf  = longint'((phase_acc >> 6) & 32'hFFFF);
        s   = sine_q23[idx] + (((sine_q23[idx + 1] - sine_q23[idx]) * pf) >>> 16);
        ms  = 7 * 65536 + ((10 * depth * (-s)) >>> 23);
        if (ms < 65536)
            ms = 65536;
        dly = (ms * reg_spms) >>> 8;
        if (dly > (longint'(sch_pkg::LINE_DEPTH - 2) << 16))
            dly = longint'(sch_pkg::LINE_DEPTH - 2) << 16;
        whole = dly[25:16];
        frac  = dly & 16'hFFFF;
        at    = wr_ptr - whole;
        for (int ch = 0; ch < 2; ch++)
        begin
            x = (ch == 0) ? dry.left : dry.right;
            line_mem[ch][wr_ptr] = int'(x);
            newer = line_mem[ch][at];
            older = line_mem[ch][at - 10'd1];
            wet = newer + ((frac * (older - newer)) >>> 16);
            y = (x * (65536 - wmix) + wet * wmix) >>> 16;
            if (y > 8388607)
                y = 8388607;
            if (y < -8388608)
                y = -8388608;
            if (ch == 0)
                res.left = y[23:0];
            else
                res.right = y[23:0];
        end
        wr_ptr = wr_ptr + 10'd1;
        phase_acc = phase_acc + rate[31:0];
        expected_frames.push_back(res);
    endtask

    // predictor follows accepted frames and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                chorus_frame('{left: left_in, right: right_in});
        end
    end

    // driver
    int feed_gap;
    always @(posedge clk or negedge rst_n)
    begin
        frame_t f;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            left_in  <= '0;
            right_in <= '0;
            feed_gap <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (feed_gap > 0)
            begin
                in_valid <= 1'b0;
                feed_gap <= feed_gap - 1;
            end
            else if (pending_frames.size() > 0)
            begin
                f = pending_frames.pop_front();
                in_valid <= 1'b1;
                left_in  <= f.left;
                right_in <= f.right;
                feed_gap <= steady_feed ? 0 : random_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor, with one long hold-off once 150 frames have been seen
    int seen_count;
    int hold_cnt;
    bit long_hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            seen_count     <= 0;
            hold_cnt       <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_count <= seen_count + 1;
                if (expected_frames.size() == 0)
                begin
                    report("unexpected item", left_out, 0);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (left_out !== want.left)
                        report("left_out", left_out, want.left);
                    if (right_out !== want.right)
                        report("right_out", right_out, want.right);
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && seen_count >= 150)
            begin
                long_hold_done <= 1'b1;
                hold_cnt       <= 400;
                out_ready      <= 1'b0;
            end
            else if (steady_feed)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                hold_cnt  <= random_gap();
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_frames.size() > 0 || in_valid || expected_frames.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_frame(input logic signed [23:0] l, input logic signed [23:0] r);
        pending_frames.push_back('{left: l, right: r});
    endtask

    function automatic logic [31:0] pick_value(input int hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 0;
        else if (r == 1)
            return hi;
        else
            return $urandom_range(0, hi);
    endfunction

    initial
    begin
        steady_feed  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        for (int i = 0; i <= sch_pkg::SINE_ENTRIES; i++)
        begin
            if (i <= sch_pkg::SINE_ENTRIES / 4)
                sine_q23[i] = quarter_wave(i);
            else if (i <= sch_pkg::SINE_ENTRIES / 2)
                sine_q23[i] = quarter_wave(sch_pkg::SINE_ENTRIES / 2 - i);
            else if (i <= 3 * sch_pkg::SINE_ENTRIES / 4)
                sine_q23[i] = -quarter_wave(i - sch_pkg::SINE_ENTRIES / 2);
            else
                sine_q23[i] = -quarter_wave(sch_pkg::SINE_ENTRIES - i);
        end
        foreach (line_mem[c, j])
            line_mem[c][j] = 0;
        wr_ptr    = '0;
        phase_acc = '0;
        reg_mix   = sch_pkg::MIX_RESET;
        reg_depth = sch_pkg::DEPTH_RESET;
        reg_rate  = sch_pkg::RATE_RESET;
        reg_spms  = sch_pkg::SPMS_RESET;
        reg_ramp  = sch_pkg::RAMP_RESET;
        glide_val[0] = reg_mix << 16;
        glide_val[1] = reg_depth << 16;
        glide_val[2] = reg_rate << 16;
        for (int k = 0; k < 3; k++)
        begin
            glide_inc[k] = 0;
            glide_cnt[k] = 0;
        end
        running = 1'b0;

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: writes before the first frame land at once, upper bits masked
        write_register(sch_pkg::REG_MIX, 32'hFFFF_FFFF);
        write_register(sch_pkg::REG_DEPTH, 32'h0001_FFFF);
        write_register(sch_pkg::REG_RATE, 32'hFF7F_FFFF);
        write_register(sch_pkg::REG_SPMS, 32'd65535);
        write_register(3'd5, 32'h1234_5678);
        write_register(3'd7, 32'hFFFF_FFFF);
        queue_frame(24'sh7FFFFF, -24'sh800000);
        queue_frame(-24'sh800000, 24'sh7FFFFF);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        queue_frame(-24'sh800000, -24'sh800000);
        queue_frame(24'sh000000, 24'shFFFFFF);
        queue_frame(24'sh555555, 24'shAAAAAA);
        wait_drained();

        // delay below one sample: zero back reads the frame just written
        write_register(sch_pkg::REG_SPMS, 32'd0);
        write_register(sch_pkg::REG_MIX, 32'd0);
        write_register(sch_pkg::REG_RAMP, 32'd0);
        queue_frame(24'sh123456, -24'sh654321);
        queue_frame(24'sh7FFFFF, -24'sh800000);
        wait_drained();
        write_register(sch_pkg::REG_MIX, 32'd65535);
        queue_frame(24'sh400000, -24'sh400000);
        queue_frame(-24'sh800000, 24'sh7FFFFF);
        wait_drained();

        // short glide, then a write in the middle of it
        write_register(sch_pkg::REG_RAMP, 32'd4);
        write_register(sch_pkg::REG_MIX, 32'd1000);
        write_register(sch_pkg::REG_DEPTH, 32'd0);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        wait_drained();
        write_register(sch_pkg::REG_MIX, 32'd60000);
        for (int i = 0; i < 6; i++)
            queue_frame(random_sample(), random_sample());
        wait_drained();

        // random phases, each starting from a fresh register setting
        for (int ph = 0; ph < 12; ph++)
        begin
            int n;
            steady_feed = (ph == 3);
            write_register(sch_pkg::REG_RAMP, ($urandom_range(0, 2) == 0) ? pick_value(16383)
                                                                 : $urandom_range(0, 40));
            if (ph == 5)
            begin
                write_register(sch_pkg::REG_SPMS, 32'd65535);
                write_register(sch_pkg::REG_DEPTH, 32'd65535);
            end
            else
            begin
                write_register(sch_pkg::REG_SPMS, ($urandom_range(0, 3) == 0) ? pick_value(65535)
                                                                     : $urandom_range(256, 12288));
                write_register(sch_pkg::REG_DEPTH, pick_value(65535));
            end
            write_register(sch_pkg::REG_MIX, pick_value(65535));
            write_register(sch_pkg::REG_RATE, ($urandom_range(0, 3) == 0) ? pick_value(8388607)
                                                                 : $urandom_range(0, 200000));
            if ($urandom_range(0, 3) == 0)
                write_register(3'($urandom_range(5, 7)), $urandom);
            n = $urandom_range(35, 60);
            for (int i = 0; i < n; i++)
                queue_frame(random_sample(), random_sample());
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
